FILE: hdl/smbs_pkg.sv
// Shared types and constants for the SPI master byte shifter.
// Holds the transfer payload structs, the sequencer phase codes and the register map.
// No dependencies.
package smbs_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] tx_byte;
    logic       open_select;
    logic       close_select;
    logic       miso_level;
  } smbs_in_t;

  typedef struct packed {
    logic       sclk_level;
    logic       mosi_level;
    logic       select_level;
    logic       busy_res;
    logic       byte_done;
    logic [7:0] rx_byte;
  } smbs_out_t;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_SETUP = 3'd1;
  localparam logic [2:0] PH_W1    = 3'd2;
  localparam logic [2:0] PH_W2    = 3'd3;
  localparam logic [2:0] PH_W3    = 3'd4;
  localparam logic [2:0] PH_HOLD  = 3'd5;

  localparam logic       REQ_TICK  = 1'b0;
  localparam logic       REQ_START = 1'b1;

  localparam logic [1:0] REG_CPOL  = 2'd0;
  localparam logic [1:0] REG_CPHA  = 2'd1;
  localparam logic [1:0] REG_DELAY = 2'd2;

  localparam logic [2:0] LAST_BIT  = 3'd7;

  function automatic logic [16:0] wait_load(input logic [15:0] delay, input logic twice);
    logic [16:0] v;
    v = twice ? {delay, 1'b0} : {1'b0, delay};
    return (v == 17'd0) ? 17'd1 : v;
  endfunction

endpackage

FILE: hdl/spi_master_byte_shifter_core.sv
// SPI master byte shifter, modes 0 to 3, MSB first.
// Sequencer, APB-style register port and registered result stage.
// Depends on smbs_pkg.
//
// Usage: each input transfer is either a tick (one unit of time passes) or a
// start (begin a byte transfer with optional chip select setup and hold).
// Every accepted item yields exactly one result transfer carrying the pin
// levels after that item, the busy flag and, on completion, the received byte.
// Each bit spans three waits of delay_ticks ticks; setup and hold span two.
// The result of an item is registered and presented in the cycle after acceptance.
// Throughput: one item per cycle unless stalled; the sequencer state is updated
// in the same cycle the item is accepted, so the next item may follow immediately.
// Stall: while a result waits and out_ready is low, in_ready drops and the
// result holds; in_ready returns in the cycle the result is taken.
// Reset (rst_n low, synchronous): sequencer idle, chip select released,
// clock and data pins low, registers at mode 0 with a delay of one tick,
// no result pending.
// Registers: 0 clock polarity, 1 clock phase, 2 delay in ticks (16 bits),
// at byte addresses 0, 4 and 8. Write them only while idle.
module spi_master_byte_shifter_core
  import smbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  smbs_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output smbs_out_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        cpol_r;
  logic        cpha_r;
  logic [15:0] delay_r;

  logic [2:0]  phase_r,  phase_nxt;
  logic [2:0]  bit_r,    bit_nxt;
  logic [16:0] wait_r,   wait_nxt;
  logic [7:0]  tx_r,     tx_nxt;
  logic [7:0]  rx_r,     rx_nxt;
  logic        sclk_r,   sclk_nxt;
  logic        mosi_r,   mosi_nxt;
  logic        sel_r,    sel_nxt;
  logic        rel_r,    rel_nxt;

  logic        out_valid_r;
  smbs_out_t   out_r,    out_nxt;

  logic        accept;
  logic        begin_bit;
  logic        done;
  logic [16:0] wait_dec;
  logic [1:0]  reg_idx;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[3:2];
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign wait_dec = wait_r - 17'd1;

  always_comb begin
    case (reg_idx)
      REG_CPOL:  prdata = {31'd0, cpol_r};
      REG_CPHA:  prdata = {31'd0, cpha_r};
      REG_DELAY: prdata = {16'd0, delay_r};
      default:   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpol_r  <= 1'b0;
      cpha_r  <= 1'b0;
      delay_r <= 16'd1;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_CPOL:  cpol_r  <= pwdata[0];
        REG_CPHA:  cpha_r  <= pwdata[0];
        REG_DELAY: delay_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    wait_nxt  = wait_r;
    tx_nxt    = tx_r;
    rx_nxt    = rx_r;
    sclk_nxt  = sclk_r;
    mosi_nxt  = mosi_r;
    sel_nxt   = sel_r;
    rel_nxt   = rel_r;
    begin_bit = 1'b0;
    done      = 1'b0;

    if (in_data.req_type == REQ_START) begin
      if (phase_r == PH_IDLE) begin
        tx_nxt  = in_data.tx_byte;
        rx_nxt  = 8'd0;
        bit_nxt = 3'd0;
        rel_nxt = in_data.close_select;
        if (in_data.open_select) begin
          sel_nxt   = 1'b0;
          phase_nxt = PH_SETUP;
          wait_nxt  = wait_load(delay_r, 1'b1);
        end else begin
          begin_bit = 1'b1;
        end
      end
    end else if (phase_r != PH_IDLE) begin
      wait_nxt = wait_dec;
      if (wait_dec == 17'd0) begin
        case (phase_r)
          PH_SETUP: begin_bit = 1'b1;
          PH_W1: begin
            if (!cpha_r) begin
              sclk_nxt = ~cpol_r;
            end else begin
              mosi_nxt = tx_r[7];
              tx_nxt   = {tx_r[6:0], 1'b0};
            end
            phase_nxt = PH_W2;
            wait_nxt  = wait_load(delay_r, 1'b0);
          end
          PH_W2: begin
            if (!cpha_r) begin
              rx_nxt = {rx_r[6:0], in_data.miso_level};
            end
            sclk_nxt  = cpol_r;
            phase_nxt = PH_W3;
            wait_nxt  = wait_load(delay_r, 1'b0);
          end
          PH_W3: begin
            if (cpha_r) begin
              rx_nxt = {rx_r[6:0], in_data.miso_level};
            end
            if (bit_r >= LAST_BIT) begin
              if (rel_r) begin
                phase_nxt = PH_HOLD;
                wait_nxt  = wait_load(delay_r, 1'b1);
              end else begin
                phase_nxt = PH_IDLE;
                done      = 1'b1;
              end
            end else begin
              bit_nxt   = bit_r + 3'd1;
              begin_bit = 1'b1;
            end
          end
          PH_HOLD: begin
            sel_nxt   = 1'b1;
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end

    if (begin_bit) begin
      if (!cpha_r) begin
        mosi_nxt = tx_nxt[7];
        tx_nxt   = {tx_nxt[6:0], 1'b0};
      end else begin
        sclk_nxt = ~cpol_r;
      end
      phase_nxt = PH_W1;
      wait_nxt  = wait_load(delay_r, 1'b0);
    end

    out_nxt.sclk_level   = sclk_nxt;
    out_nxt.mosi_level   = mosi_nxt;
    out_nxt.select_level = sel_nxt;
    out_nxt.busy_res     = (phase_nxt != PH_IDLE);
    out_nxt.byte_done    = done;
    out_nxt.rx_byte      = done ? rx_nxt : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_r       <= 3'd0;
      wait_r      <= 17'd0;
      tx_r        <= 8'd0;
      rx_r        <= 8'd0;
      sclk_r      <= 1'b0;
      mosi_r      <= 1'b0;
      sel_r       <= 1'b1;
      rel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        bit_r   <= bit_nxt;
        wait_r  <= wait_nxt;
        tx_r    <= tx_nxt;
        rx_r    <= rx_nxt;
        sclk_r  <= sclk_nxt;
        mosi_r  <= mosi_nxt;
        sel_r   <= sel_nxt;
        rel_r   <= rel_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: hdl/smbs_checker.sv
// Port-level checks for the SPI master byte shifter.
// Bound to spi_master_byte_shifter_core; depends on smbs_pkg.
module smbs_checker
  import smbs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input smbs_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_done |-> !out_data.busy_res)
    else $error("transfer completed while still busy");

  a_rx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_done |-> out_data.rx_byte == 8'd0)
    else $error("received byte shown without completion");

endmodule

bind spi_master_byte_shifter_core smbs_checker u_smbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
